// ===== hdl/febm_pkg.sv =====
// shared types, constants and the control store of the block map translator
package febm_pkg;

  // entry layout and table size
  localparam int unsigned ENTRY_BYTES = 512;
  localparam int unsigned TABLE_DEPTH = 240;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned START_W = 24;
  localparam int unsigned RD_W    = 15;
  localparam int unsigned BS_W    = 17;
  localparam int unsigned BLK_W   = 16;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned NAME_W  = 24;
  localparam int unsigned PART_W  = 8;
  localparam int unsigned SIZE_W  = 32;

  localparam int unsigned EPOS_W = $clog2(ENTRY_BYTES);
  localparam int unsigned TBL_AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);

  // block size clamp
  localparam int unsigned BS_MIN_LOG = 9;
  localparam logic [BS_W-1:0] BS_MIN = BS_W'(1 << BS_MIN_LOG);
  localparam logic [BS_W-1:0] BS_MAX = BS_W'(65536);

  // logical position = start + done, quotient by a block size of at least BS_MIN
  localparam int unsigned POS_W     = START_W + 1;
  localparam int unsigned IDX_W     = POS_W - BS_MIN_LOG;
  localparam int unsigned DIV_CNT_W = $clog2(IDX_W + 1);

  localparam int unsigned MAX_CHUNKS = 33;
  localparam int unsigned NCH_W      = $clog2(MAX_CHUNKS);

  // entry byte offsets
  localparam logic [EPOS_W-1:0] POS_NAME0 = EPOS_W'(9);
  localparam logic [EPOS_W-1:0] POS_NAME1 = EPOS_W'(10);
  localparam logic [EPOS_W-1:0] POS_NAME2 = EPOS_W'(11);
  localparam logic [EPOS_W-1:0] POS_SIZE0 = EPOS_W'(12);
  localparam logic [EPOS_W-1:0] POS_SIZE1 = EPOS_W'(13);
  localparam logic [EPOS_W-1:0] POS_SIZE2 = EPOS_W'(14);
  localparam logic [EPOS_W-1:0] POS_SIZE3 = EPOS_W'(15);
  localparam logic [EPOS_W-1:0] POS_PART  = EPOS_W'(17);
  localparam logic [EPOS_W-1:0] POS_TBL   = EPOS_W'(32);
  localparam logic [EPOS_W-1:0] POS_LAST  = EPOS_W'(ENTRY_BYTES - 1);

  localparam logic [BYTE_W-1:0] BYTE_EMPTY  = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_ERASED = 8'hff;
  localparam logic [BLK_W-1:0]  BLK_SKIP    = 16'hffff;

  // control store
  localparam int unsigned STEP_W = 4;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_BYTE,
    ACT_MUL_MIN,
    ACT_EMIT_BYTE,
    ACT_DIV_GO,
    ACT_DIV_TAKE,
    ACT_MUL_TBL,
    ACT_EMIT_CHUNK,
    ACT_NEXT
  } act_e;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_NO_IN,
    COND_READ,
    COND_ZERO,
    COND_DIV,
    COND_LAST,
    COND_ALWAYS
  } cond_e;

  typedef struct packed {
    act_e              act;
    cond_e             cond;
    logic              emit;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic is_read;
    logic zero_count;
    logic div_busy;
    logic last;
    logic out_busy;
  } flags_t;

  localparam logic [STEP_W-1:0] ST_IDLE      = 4'd0;
  localparam logic [STEP_W-1:0] ST_DISPATCH  = 4'd1;
  localparam logic [STEP_W-1:0] ST_BYTE      = 4'd2;
  localparam logic [STEP_W-1:0] ST_BYTE_MIN  = 4'd3;
  localparam logic [STEP_W-1:0] ST_BYTE_EMIT = 4'd4;
  localparam logic [STEP_W-1:0] ST_RD_DIV    = 4'd5;
  localparam logic [STEP_W-1:0] ST_RD_MIN    = 4'd6;
  localparam logic [STEP_W-1:0] ST_RD_WAIT   = 4'd7;
  localparam logic [STEP_W-1:0] ST_RD_TAKE   = 4'd8;
  localparam logic [STEP_W-1:0] ST_CH_READ   = 4'd9;
  localparam logic [STEP_W-1:0] ST_CH_MUL    = 4'd10;
  localparam logic [STEP_W-1:0] ST_CH_EMIT   = 4'd11;
  localparam logic [STEP_W-1:0] ST_CH_NEXT   = 4'd12;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t cw;
    unique case (step)
      ST_IDLE:      cw = '{ACT_ACCEPT,     COND_NO_IN,  1'b0, ST_IDLE};
      ST_DISPATCH:  cw = '{ACT_NONE,       COND_READ,   1'b0, ST_RD_DIV};
      ST_BYTE:      cw = '{ACT_BYTE,       COND_NONE,   1'b0, ST_IDLE};
      ST_BYTE_MIN:  cw = '{ACT_MUL_MIN,    COND_NONE,   1'b0, ST_IDLE};
      ST_BYTE_EMIT: cw = '{ACT_EMIT_BYTE,  COND_ALWAYS, 1'b1, ST_IDLE};
      ST_RD_DIV:    cw = '{ACT_DIV_GO,     COND_ZERO,   1'b0, ST_IDLE};
      ST_RD_MIN:    cw = '{ACT_MUL_MIN,    COND_NONE,   1'b0, ST_IDLE};
      ST_RD_WAIT:   cw = '{ACT_NONE,       COND_DIV,    1'b0, ST_RD_WAIT};
      ST_RD_TAKE:   cw = '{ACT_DIV_TAKE,   COND_NONE,   1'b0, ST_IDLE};
      ST_CH_READ:   cw = '{ACT_NONE,       COND_NONE,   1'b0, ST_IDLE};
      ST_CH_MUL:    cw = '{ACT_MUL_TBL,    COND_NONE,   1'b0, ST_IDLE};
      ST_CH_EMIT:   cw = '{ACT_EMIT_CHUNK, COND_LAST,   1'b1, ST_IDLE};
      ST_CH_NEXT:   cw = '{ACT_NEXT,       COND_ALWAYS, 1'b0, ST_CH_READ};
      default:      cw = '{ACT_NONE,       COND_ALWAYS, 1'b0, ST_IDLE};
    endcase
    return cw;
  endfunction

endpackage

// ===== hdl/febm_ram.sv =====
// generic single write port ram with registered read
module febm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 240,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/febm_div.sv =====
// restoring divider, one quotient bit per cycle
module febm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [febm_pkg::POS_W-1:0] dividend_i,
  input  logic [febm_pkg::BS_W-1:0]  divisor_i,
  output logic                       busy_o,
  output logic [febm_pkg::IDX_W-1:0] quot_o,
  output logic [febm_pkg::BS_W-1:0]  rem_o
);
  import febm_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [BS_W-1:0]      rem_q, rem_d;
  logic [IDX_W-1:0]     num_q, num_d;
  logic [BS_W-1:0]      div_q, div_d;
  logic [BS_W:0]        trial;
  logic [BS_W:0]        diff;
  logic                 ge;

  always_comb begin
    trial = {rem_q, num_q[IDX_W-1]};
    diff  = trial - {1'b0, div_q};
    ge    = trial >= {1'b0, div_q};
    cnt_d = cnt_q;
    rem_d = rem_q;
    num_d = num_q;
    div_d = div_q;
    if (start_i) begin
      // top bits are below the smallest divisor, so no quotient bits there
      rem_d = {{(BS_W - (POS_W - IDX_W)){1'b0}}, dividend_i[POS_W-1:IDX_W]};
      num_d = dividend_i[IDX_W-1:0];
      div_d = divisor_i;
      cnt_d = DIV_CNT_W'(IDX_W);
    end else if (cnt_q != '0) begin
      rem_d = ge ? diff[BS_W-1:0] : trial[BS_W-1:0];
      num_d = {num_q[IDX_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    div_q <= div_d;
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = num_q;
  assign rem_o  = rem_q;

endmodule

// ===== hdl/febm_seq.sv =====
// step counter and control store lookup
module febm_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  febm_pkg::flags_t  flags_i,
  output febm_pkg::ucode_t  cw_o
);
  import febm_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            cw;
  logic              jump;
  logic              stall;

  always_comb begin
    cw    = ucode_rom(step_q);
    stall = cw.emit && flags_i.out_busy;
    unique case (cw.cond)
      COND_NONE:   jump = 1'b0;
      COND_NO_IN:  jump = !flags_i.in_valid;
      COND_READ:   jump = flags_i.is_read;
      COND_ZERO:   jump = flags_i.zero_count;
      COND_DIV:    jump = flags_i.div_busy;
      COND_LAST:   jump = flags_i.last;
      COND_ALWAYS: jump = 1'b1;
      default:     jump = 1'b1;
    endcase
    priority if (stall) begin
      step_d = step_q;
    end else if (jump) begin
      step_d = cw.target;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign cw_o = cw;

endmodule

// ===== hdl/fat_entry_block_map.sv =====
// directory entry loader and block map address translator, top level
//
//  channel | direction | transaction                     | handshake
//  --------+-----------+---------------------------------+--------------------------
//  in      | input     | entry byte or read request      | in_valid_i / in_ready_o
//  out     | output    | entry fields plus one chunk     | out_valid_o / out_ready_i
//  cfg     | input     | block size write                | cfg_we_i, no wait
//
// one input transaction at a time, steps come from a small control store.
// entry byte: dispatch, byte store, min block multiply, then the result is loaded; the
// next byte can be taken in the cycle after the result is loaded.
// read request: first chunk loaded via dispatch, divider start, shift-subtract
// division (with the min block multiply alongside), a wait step that sees it finish,
// take, table read, multiply, result; every chunk after that takes advance, table
// read, multiply, result, up to 33 chunks. a zero-count read goes back to idle
// after dispatch and the divider start step, with no result.
// reset clears all entry state and sets the block size to 512; the block
// table has no clear and its entries are only used below the stored block count.
// a full output register stalls the sequencer on its result step only.
module fat_entry_block_map (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [febm_pkg::BS_W-1:0]      cfg_wdata_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           req_type_i,
  input  logic [febm_pkg::BYTE_W-1:0]    entry_byte_i,
  input  logic [febm_pkg::START_W-1:0]   read_start_i,
  input  logic [febm_pkg::RD_W-1:0]      read_count_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           entry_valid_o,
  output logic [febm_pkg::NAME_W-1:0]    name_chars_o,
  output logic [febm_pkg::PART_W-1:0]    part_number_o,
  output logic [febm_pkg::SIZE_W-1:0]    file_size_o,
  output logic [febm_pkg::ADDR_W-1:0]    first_block_address_o,
  output logic [febm_pkg::ADDR_W-1:0]    phys_address_o,
  output logic [febm_pkg::BS_W-1:0]      chunk_length_o,
  output logic                           last_chunk_o,
  output logic                           out_of_range_o
);
  import febm_pkg::*;

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  ucode_t cw;
  flags_t flags;
  logic   accept;
  logic   out_busy;
  logic   emit_fire;
  logic   out_valid_q;

  febm_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .cw_o    (cw)
  );

  assign in_ready_o = cw.act == ACT_ACCEPT;
  assign accept     = in_valid_i && in_ready_o;
  assign out_busy   = out_valid_q && !out_ready_i;
  assign emit_fire  = cw.emit && !out_busy;

  // ---------------------------------------------------------------------
  // configuration, block size clamped to the legal range
  // ---------------------------------------------------------------------
  logic [BS_W-1:0] bs_q;
  logic [BS_W-1:0] bs_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q <= BS_MIN;
    end else if (cfg_we_i) begin
      bs_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    priority if (bs_q < BS_MIN) begin
      bs_eff = BS_MIN;
    end else if (bs_q > BS_MAX) begin
      bs_eff = BS_MAX;
    end else begin
      bs_eff = bs_q;
    end
  end

  // ---------------------------------------------------------------------
  // captured input transaction
  // ---------------------------------------------------------------------
  logic               req_type_q;
  logic [BYTE_W-1:0]  byte_q;
  logic [START_W-1:0] start_q;
  logic [RD_W-1:0]    rd_count_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q <= req_type_i;
      byte_q     <= entry_byte_i;
      start_q    <= read_start_i;
      rd_count_q <= read_count_i;
    end
  end

  // ---------------------------------------------------------------------
  // entry state
  // ---------------------------------------------------------------------
  logic [EPOS_W-1:0] epos_q, epos_d;
  logic [CNT_W-1:0]  blk_cnt_q, blk_cnt_d;
  logic [BYTE_W-1:0] low_q, low_d;
  logic [BLK_W-1:0]  min_q, min_d;
  logic              valid_q, valid_d;
  logic [NAME_W-1:0] name_q, name_d;
  logic [PART_W-1:0] part_q, part_d;
  logic [SIZE_W-1:0] size_q, size_d;

  logic [BLK_W-1:0]  blk_num;
  logic              tbl_we;
  logic [BLK_W-1:0]  tbl_rdata;
  logic              do_byte;

  assign do_byte = cw.act == ACT_BYTE;
  assign blk_num = {byte_q, low_q};

  always_comb begin
    epos_d    = epos_q;
    blk_cnt_d = blk_cnt_q;
    low_d     = low_q;
    min_d     = min_q;
    valid_d   = valid_q;
    name_d    = name_q;
    part_d    = part_q;
    size_d    = size_q;
    tbl_we    = 1'b0;
    if (do_byte) begin
      epos_d = (epos_q == POS_LAST) ? '0 : epos_q + 1'b1;
      if (epos_q == '0) begin
        // start of a new entry
        blk_cnt_d = '0;
        low_d     = '0;
        min_d     = BLK_SKIP;
        name_d    = '0;
        part_d    = '0;
        size_d    = '0;
        valid_d   = (byte_q != BYTE_EMPTY) && (byte_q != BYTE_ERASED);
      end else if (valid_q) begin
        priority if (epos_q == POS_NAME0) begin
          name_d[7:0] = byte_q;
        end else if (epos_q == POS_NAME1) begin
          name_d[15:8] = byte_q;
        end else if (epos_q == POS_NAME2) begin
          name_d[23:16] = byte_q;
        end else if (epos_q == POS_SIZE0) begin
          size_d[7:0] = byte_q;
        end else if (epos_q == POS_SIZE1) begin
          size_d[15:8] = byte_q;
        end else if (epos_q == POS_SIZE2) begin
          size_d[23:16] = byte_q;
        end else if (epos_q == POS_SIZE3) begin
          size_d[31:24] = byte_q;
        end else if (epos_q == POS_PART) begin
          part_d = byte_q;
        end else if (epos_q >= POS_TBL) begin
          // table base is even: low byte on even positions
          if (!epos_q[0]) begin
            low_d = byte_q;
          end else if (blk_num != BLK_SKIP && blk_cnt_q < CNT_W'(TABLE_DEPTH)) begin
            tbl_we    = 1'b1;
            blk_cnt_d = blk_cnt_q + 1'b1;
            if (blk_num < min_q) begin
              min_d = blk_num;
            end
          end
        end else begin
          // reserved entry bytes are skipped
          epos_d = epos_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epos_q    <= '0;
      blk_cnt_q <= '0;
      low_q     <= '0;
      min_q     <= BLK_SKIP;
      valid_q   <= 1'b0;
      name_q    <= '0;
      part_q    <= '0;
      size_q    <= '0;
    end else begin
      epos_q    <= epos_d;
      blk_cnt_q <= blk_cnt_d;
      low_q     <= low_d;
      min_q     <= min_d;
      valid_q   <= valid_d;
      name_q    <= name_d;
      part_q    <= part_d;
      size_q    <= size_d;
    end
  end

  // ---------------------------------------------------------------------
  // read request walk
  // ---------------------------------------------------------------------
  logic [RD_W-1:0]  done_q, done_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [BS_W-1:0]  off_q, off_d;
  logic [NCH_W-1:0] nch_q, nch_d;

  logic             div_busy;
  logic [IDX_W-1:0] div_quot;
  logic [BS_W-1:0]  div_rem;
  logic [POS_W-1:0] log_pos;
  logic             div_start;

  assign log_pos   = {1'b0, start_q} + {{(POS_W - RD_W){1'b0}}, done_q};
  assign div_start = (cw.act == ACT_DIV_GO) && (rd_count_q != '0);

  // only the first chunk needs a division, later chunks start on a boundary
  febm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (log_pos),
    .divisor_i  (bs_eff),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  febm_ram #(
    .WIDTH (BLK_W),
    .DEPTH (TABLE_DEPTH)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (blk_cnt_q[TBL_AW-1:0]),
    .wdata_i (blk_num),
    .raddr_i (idx_q[TBL_AW-1:0]),
    .rdata_o (tbl_rdata)
  );

  // chunk length and end of request
  logic [RD_W-1:0] remain;
  logic [BS_W-1:0] len_full;
  logic [BS_W-1:0] chunk_len;
  logic            chunk_last;
  logic            chunk_oor;

  always_comb begin
    remain     = rd_count_q - done_q;
    len_full   = bs_eff - off_q;
    chunk_len  = ({{(BS_W - RD_W){1'b0}}, remain} < len_full) ?
                 {{(BS_W - RD_W){1'b0}}, remain} : len_full;
    chunk_last = (len_full >= {{(BS_W - RD_W){1'b0}}, remain}) ||
                 (nch_q == NCH_W'(MAX_CHUNKS - 1));
    chunk_oor  = idx_q >= {{(IDX_W - CNT_W){1'b0}}, blk_cnt_q};
  end

  always_comb begin
    done_d = done_q;
    idx_d  = idx_q;
    off_d  = off_q;
    nch_d  = nch_q;
    unique case (cw.act)
      ACT_ACCEPT: begin
        if (accept) begin
          done_d = '0;
          nch_d  = '0;
        end
      end
      ACT_DIV_TAKE: begin
        idx_d = div_quot;
        off_d = div_rem;
      end
      ACT_NEXT: begin
        // a chunk that is not the last never passes the request count
        done_d = done_q + chunk_len[RD_W-1:0];
        idx_d  = idx_q + 1'b1;
        off_d  = '0;
        nch_d  = nch_q + 1'b1;
      end
      default: begin
        done_d = done_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
      nch_q  <= '0;
    end else begin
      done_q <= done_d;
      nch_q  <= nch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    off_q <= off_d;
  end

  // ---------------------------------------------------------------------
  // shared multiplier: min block or table entry times block size
  // ---------------------------------------------------------------------
  logic [BLK_W-1:0]      mul_a;
  logic [BLK_W+BS_W-1:0] mul_full;
  logic [ADDR_W-1:0]     first_q;
  logic [ADDR_W-1:0]     prod_q;

  assign mul_a    = (cw.act == ACT_MUL_MIN) ? min_q : tbl_rdata;
  assign mul_full = {{BS_W{1'b0}}, mul_a} * {{BLK_W{1'b0}}, bs_eff};

  always_ff @(posedge clk_i) begin
    if (cw.act == ACT_MUL_MIN) begin
      first_q <= (blk_cnt_q == '0) ? '0 : mul_full[ADDR_W-1:0];
    end
    if (cw.act == ACT_MUL_TBL) begin
      prod_q <= mul_full[ADDR_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // flags to the sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    flags.in_valid   = in_valid_i;
    flags.is_read    = req_type_q;
    flags.zero_count = rd_count_q == '0;
    flags.div_busy   = div_busy;
    flags.last       = chunk_last;
    flags.out_busy   = out_busy;
  end

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  logic [ADDR_W-1:0] phys_q;
  logic [BS_W-1:0]   len_q;
  logic              last_q;
  logic              oor_q;
  logic              ov_q;
  logic [NAME_W-1:0] on_q;
  logic [PART_W-1:0] op_q;
  logic [SIZE_W-1:0] os_q;
  logic [ADDR_W-1:0] of_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      ov_q <= valid_q;
      on_q <= name_q;
      op_q <= part_q;
      os_q <= size_q;
      of_q <= first_q;
      if (cw.act == ACT_EMIT_CHUNK) begin
        phys_q <= chunk_oor ? '0 : prod_q + {{(ADDR_W - BS_W){1'b0}}, off_q};
        len_q  <= chunk_len;
        last_q <= chunk_last;
        oor_q  <= chunk_oor;
      end else begin
        phys_q <= '0;
        len_q  <= '0;
        last_q <= 1'b1;
        oor_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o           = out_valid_q;
  assign entry_valid_o         = ov_q;
  assign name_chars_o          = on_q;
  assign part_number_o         = op_q;
  assign file_size_o           = os_q;
  assign first_block_address_o = of_q;
  assign phys_address_o        = phys_q;
  assign chunk_length_o        = len_q;
  assign last_chunk_o          = last_q;
  assign out_of_range_o        = oor_q;

endmodule
